/* rtl/exact_division_odd_mod_2_32_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the exact division block
// Shared helpers for clocked checks that are disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef EXACT_DIVISION_ODD_MOD_2_32_DEFINES_SVH
`define EXACT_DIVISION_ODD_MOD_2_32_DEFINES_SVH

// Checks a property on every rising edge of clk outside reset.
`define EXDIV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds on a rising edge of clk outside reset.
`define EXDIV_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/exdiv_pkg.sv */
// ----------------------------------------------------------------------------
// Exact division package
// Widths and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package exdiv_pkg;

    localparam int DW    = 32;
    localparam int CNT_W = $clog2(DW);

    typedef logic [DW-1:0] word_t;

    typedef struct packed {
        logic load;     // take a new dividend and divisor
        logic step;     // one quotient bit
        logic publish;  // move the finished quotient to the output register
    } dp_cmd_t;

    typedef struct packed {
        logic last_step; // the step under way yields the top quotient bit
        logic out_busy;  // the output register holds a beat that is not taken
    } dp_stat_t;

endpackage

/* rtl/exdiv_ctrl.sv */
// ----------------------------------------------------------------------------
// Exact division controller
// Sequences load, the bit steps and the hand-over to the output register.
// ----------------------------------------------------------------------------
module exdiv_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  exdiv_pkg::dp_stat_t stat,
    output exdiv_pkg::dp_cmd_t  cmd
);
    import exdiv_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                if (stat.last_step)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/exdiv_dp.sv */
// ----------------------------------------------------------------------------
// Exact division datapath
// Produces the quotient one bit a cycle, lowest bit first, by Hensel division.
// ----------------------------------------------------------------------------
module exdiv_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  exdiv_pkg::word_t    dividend,
    input  exdiv_pkg::word_t    divisor,
    input  exdiv_pkg::dp_cmd_t  cmd,
    output exdiv_pkg::dp_stat_t stat,
    output exdiv_pkg::word_t    quotient,
    output logic                even_flag,
    output logic                out_valid,
    input  logic                out_ready
);
    import exdiv_pkg::*;

    word_t            rem_reg;
    word_t            rem_next;
    word_t            div_reg;
    word_t            q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             even_reg;
    word_t            out_q_reg;
    logic             out_even_reg;
    logic             out_valid_reg;

    // With an odd divisor the low remainder bit is the next quotient bit;
    // subtracting the divisor clears it, so the remainder can shift down.
    always_comb
    begin
        if (rem_reg[0])
        begin
            rem_next = (rem_reg - div_reg) >> 1;
        end
        else
        begin
            rem_next = rem_reg >> 1;
        end
    end

    assign stat.last_step = (cnt_reg == CNT_W'(DW - 1));
    assign stat.out_busy  = out_valid_reg && !out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rem_reg  <= dividend;
            div_reg  <= divisor;
            even_reg <= ~divisor[0];
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_next;
            q_reg   <= {rem_reg[0], q_reg[DW-1:1]};
        end
        if (cmd.publish)
        begin
            out_q_reg    <= even_reg ? '0 : q_reg;
            out_even_reg <= even_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign quotient  = out_q_reg;
    assign even_flag = out_even_reg;
    assign out_valid = out_valid_reg;

endmodule

/* rtl/exact_division_odd_mod_2_32.sv */
// An accepted input beat runs through the quotient loop, one bit per cycle, and its
// quotient goes to the output register once it is free; then a new beat is taken.
// The output register lets a result wait while the next item is computed.
// Reset (rst_n, asynchronous, active low) clears the controller and output valid.
// ----------------------------------------------------------------------------
// Exact division by an odd divisor modulo 2^32
// Returns q = dividend / divisor for an odd divisor; flags an even one and returns zero.
// ----------------------------------------------------------------------------
`include "exact_division_odd_mod_2_32_defines.svh"

module exact_division_odd_mod_2_32 (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [2*exdiv_pkg::DW-1:0] s_axis_tdata,  // dividend_value, divisor_value
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [exdiv_pkg::DW-1:0]   m_axis_tdata,  // quotient_value
    output logic [0:0]                 m_axis_tuser   // divisor_even_flag
);
    import exdiv_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    exdiv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    exdiv_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .dividend  (s_axis_tdata[DW-1:0]),
        .divisor   (s_axis_tdata[2*DW-1:DW]),
        .cmd       (cmd),
        .stat      (stat),
        .quotient  (m_axis_tdata),
        .even_flag (m_axis_tuser[0]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready)
    );

    `EXDIV_ASSERT(a_publish_valid, cmd.publish |=> m_axis_tvalid, "publish did not raise tvalid")
    `EXDIV_ASSERT(a_even_zero, (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0), "even divisor with non-zero quotient")
    `EXDIV_ASSERT(a_busy_after_accept, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "accepted a beat while busy")
    `EXDIV_NEVER(a_cmd_clash, cmd.load && (cmd.step || cmd.publish), "load issued with another command")

endmodule

/* dv/exdiv_quotient_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Quotient checker for the exact division block
// Watches the input and result streams. It works out the quotient of every
// accepted beat with an odd divisor from the divisor's inverse modulo 2^32, and it
// compares each result beat with the oldest quotient still outstanding.
// ----------------------------------------------------------------------------
module exdiv_quotient_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [2*exdiv_pkg::DW-1:0] s_tdata,   // dividend_value, divisor_value
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [exdiv_pkg::DW-1:0]   m_tdata,   // quotient_value
    input  logic [0:0]                 m_tuser,   // divisor_even_flag
    output int                         fail_count,
    output int                         pending
);

    import exdiv_pkg::*;

    typedef struct packed {
        word_t quotient;
        logic  divisor_even;
    } quotient_beat_t;

    quotient_beat_t outstanding_quotients [$];

    // Newton steps on an odd value: every step doubles the number of correct
    // low bits, so five steps from a three-bit start cover the whole word.
    function automatic word_t divisor_inverse(input word_t divisor);
        word_t x;
        int    i;
        x = divisor;
        for (i = 0; i < 5; i++)
            x = x * (word_t'(2) - divisor * x);
        return x;
    endfunction

    function automatic quotient_beat_t predict_quotient(input word_t dividend,
                                                        input word_t divisor);
        quotient_beat_t beat;
        if (!divisor[0])
        begin
            beat.quotient     = '0;
            beat.divisor_even = 1'b1;
        end
        else
        begin
            beat.quotient     = dividend * divisor_inverse(divisor);
            beat.divisor_even = 1'b0;
        end
        return beat;
    endfunction

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge clk)
    begin : watch
        quotient_beat_t want;
        if (rst_n)
        begin
            // A result beat always belongs to an older input, so it is checked
            // before the input beat of the same edge is queued.
            if (m_tvalid && m_tready)
            begin
                if (outstanding_quotients.size() == 0)
                begin
                    $error("result beat with no quotient outstanding: quotient_value %h",
                           m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = outstanding_quotients.pop_front();
                    if (m_tdata !== want.quotient)
                    begin
                        $error("quotient_value: expected %h, got %h",
                               want.quotient, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser[0] !== want.divisor_even)
                    begin
                        $error("divisor_even_flag: expected %b, got %b",
                               want.divisor_even, m_tuser[0]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                outstanding_quotients.push_back(
                    predict_quotient(s_tdata[DW-1:0], s_tdata[2*DW-1:DW]));
            pending = outstanding_quotients.size();
        end
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench top for the exact division block
// Sends directed corner beats, then random odd and even divisors, in bursts.
// The result side stalls on its own pattern and holds off once for a long
// stretch. The quotient checker does the comparison; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

    import exdiv_pkg::*;

    localparam int RANDOM_ITEMS   = 480;
    localparam int HOLD_OFF_AFTER = 120;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 40;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int DIRECTED_ITEMS = 22;

    // Each entry is {divisor, dividend}, as it sits in tdata.
    localparam logic [2*DW-1:0] DIRECTED_BEATS [0:DIRECTED_ITEMS-1] = '{
        {32'h0000_0001, 32'h0000_0000},
        {32'h0000_0001, 32'hFFFF_FFFF},
        {32'hFFFF_FFFF, 32'hFFFF_FFFF},
        {32'hFFFF_FFFF, 32'h0000_0001},
        {32'h0000_0000, 32'h0000_0000},
        {32'h0000_0000, 32'h1234_5678},
        {32'h0000_0002, 32'hFFFF_FFFF},
        {32'h8000_0000, 32'h0000_0001},
        {32'hFFFF_FFFE, 32'hFFFF_FFFE},
        {32'h0000_0003, 32'h0000_0003},
        {32'h0000_0003, 32'h0000_0001},
        {32'h0000_0003, 32'h5555_5555},
        {32'hAAAA_AAAB, 32'h0000_0001},
        {32'h5555_5555, 32'hFFFF_FFFF},
        {32'h0000_0009, 32'h0000_0051},
        {32'hCFD4_1B91, 32'h0000_0001},
        {32'h8000_0001, 32'h8000_0000},
        {32'h7FFF_FFFF, 32'h7FFF_FFFF},
        {32'h0000_0005, 32'hAAAA_AAAA},
        {32'hFFFF_FFFD, 32'h0000_0003},
        {32'h0001_0001, 32'h0000_FFFF},
        {32'h0000_001B, 32'h0000_0000}
    };

    logic            clk           = 1'b0;
    logic            rst_n         = 1'b0;
    logic            s_axis_tvalid = 1'b0;
    logic            s_axis_tready;
    logic [2*DW-1:0] s_axis_tdata  = '0;     // dividend_value, divisor_value
    logic            m_axis_tvalid;
    logic            m_axis_tready = 1'b0;
    logic [DW-1:0]   m_axis_tdata;           // quotient_value
    logic [0:0]      m_axis_tuser;           // divisor_even_flag

    int fail_count;
    int pending;
    int items_sent  = 0;
    int burst_left  = 0;
    int cycle_count = 0;

    exact_division_odd_mod_2_32 uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    exdiv_quotient_checker u_quotient_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_axis_tvalid),
        .s_tready   (s_axis_tready),
        .s_tdata    (s_axis_tdata),
        .m_tvalid   (m_axis_tvalid),
        .m_tready   (m_axis_tready),
        .m_tdata    (m_axis_tdata),
        .m_tuser    (m_axis_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("exact_division_odd_mod_2_32 regression: fail");
            $finish;
        end
    end

    // Offers one beat. Bursts of random length are separated by random gaps;
    // valid is only lowered when a real gap follows.
    task automatic offer_beat(input word_t dividend, input word_t divisor);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {divisor, dividend};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        burst_left--;
        items_sent++;
    endtask

    // Result side: phases of different stall behaviour, and one long hold-off
    // so that the output register and the datapath both fill up.
    initial
    begin : result_sink
        int  phase_len;
        int  mode;
        bit  held_off;
        held_off = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode      = $urandom_range(0, 3);
            phase_len = $urandom_range(20, 300);
            repeat (phase_len)
            begin
                @(posedge clk);
                if (!held_off && items_sent >= HOLD_OFF_AFTER)
                begin
                    held_off = 1'b1;
                    m_axis_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= $urandom_range(0, 1);
                    2:       m_axis_tready <= ($urandom_range(0, 7) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        word_t dividend;
        word_t divisor;
        word_t pow3;
        int    n;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < DIRECTED_ITEMS; n++)
            offer_beat(DIRECTED_BEATS[n][DW-1:0], DIRECTED_BEATS[n][2*DW-1:DW]);

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    divisor = $urandom & ~word_t'(1);
                    if ($urandom_range(0, 7) == 0)
                        divisor = '0;
                end
                1:       divisor = $urandom_range(0, 63) * 2 + 1;
                2:
                begin
                    // Powers of three times a small odd factor give odd divisors
                    // built from many factors of three.
                    pow3 = 1;
                    repeat ($urandom_range(1, 20)) pow3 = pow3 * 3;
                    divisor = pow3 * ($urandom_range(0, 15) * 2 + 1);
                end
                3:       divisor = 32'hFFFF_FFFF - 2 * $urandom_range(0, 63);
                default: divisor = $urandom | word_t'(1);
            endcase
            case ($urandom_range(0, 4))
                0, 1:    dividend = word_t'($urandom) * divisor;
                2:       dividend = $urandom_range(0, 255);
                3:       dividend = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
                default: dividend = $urandom;
            endcase
            offer_beat(dividend, divisor);
        end
        s_axis_tvalid <= 1'b0;

        // The checker queues the last beat at the edge that accepted it, so
        // the outstanding count is only read from the following edge on.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("exact_division_odd_mod_2_32 regression: pass");
        else
            $display("exact_division_odd_mod_2_32 regression: fail");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/exdiv_pkg.sv
rtl/exdiv_ctrl.sv
rtl/exdiv_dp.sv
rtl/exact_division_odd_mod_2_32.sv
dv/exdiv_quotient_checker.sv
dv/tb_top.sv
